/* hdl/wphs_pkg.sv */
// ----------------------------------------------------------------------------
// wphs_pkg
// Constants and angle table for the waypoint heading / standoff pipeline.
// ----------------------------------------------------------------------------
package wphs_pkg;

  localparam int COORD_WIDTH_DEF   = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int XW = 64;   // CORDIC vector datapath
  localparam int UW = 40;   // standoff vector datapath
  localparam int ZW = 27;   // angle, degrees Q16
  localparam int BW = 17;   // bearing, degrees Q8

  localparam int TABLE_LEN = 24;

  localparam logic [23:0]       INV_GAIN_Q24 = 24'd10187995;
  localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] DEG360_Q16 = ZW'(360 * 65536);
  localparam logic [18:0]       DEG360_Q8    = 19'd92160;

  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = ZW'(2949120);
      1:  r = ZW'(1740967);
      2:  r = ZW'(919879);
      3:  r = ZW'(466945);
      4:  r = ZW'(234379);
      5:  r = ZW'(117304);
      6:  r = ZW'(58666);
      7:  r = ZW'(29335);
      8:  r = ZW'(14668);
      9:  r = ZW'(7334);
      10: r = ZW'(3667);
      11: r = ZW'(1833);
      12: r = ZW'(917);
      13: r = ZW'(458);
      14: r = ZW'(229);
      15: r = ZW'(115);
      16: r = ZW'(57);
      17: r = ZW'(29);
      18: r = ZW'(14);
      19: r = ZW'(7);
      20: r = ZW'(4);
      21: r = ZW'(2);
      22: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/waypoint_heading_standoff.sv */
// ----------------------------------------------------------------------------
// waypoint_heading_standoff
// One beat per cycle unless the output stalls. The datapath is a fully
// pipelined CORDIC vectoring chain, one micro-rotation per stage, followed
// by a split inverse-gain multiply.
// A stall on the output holds the whole pipeline.
// Synchronous reset clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module waypoint_heading_standoff #(
  parameter int COORD_WIDTH   = wphs_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = wphs_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // vehicle_north, vehicle_east, goal_north, goal_east, stop_distance
  input  logic [((5*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // target_east, target_north, bearing_deg
  output logic [((2*COORD_WIDTH+wphs_pkg::BW+7)/8)*8-1:0] m_tdata
);
  import wphs_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int N   = CORDIC_STAGES;
  localparam int VS  = 60 - W;
  localparam int SS  = 37 - W;
  localparam int PW  = 66;
  localparam int OBW = ((2*W+BW+7)/8)*8;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // diff stage
  logic                d_valid;
  logic signed [W:0]   d_de, d_dn;
  logic signed [W-1:0] d_ge, d_gn, d_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= s_tvalid;
    end
    if (en) begin
      d_ge <= s_tdata[3*W +: W];
      d_gn <= s_tdata[2*W +: W];
      d_d  <= s_tdata[4*W +: W];
      d_de <= (W+1)'($signed(s_tdata[3*W +: W])) - (W+1)'($signed(s_tdata[W +: W]));
      d_dn <= (W+1)'($signed(s_tdata[2*W +: W])) - (W+1)'($signed(s_tdata[0 +: W]));
    end
  end

  // cordic chain
  logic                 c_valid [0:N];
  logic signed [XW-1:0] c_x     [0:N];
  logic signed [XW-1:0] c_y     [0:N];
  logic signed [UW-1:0] c_u     [0:N];
  logic signed [UW-1:0] c_v     [0:N];
  logic signed [ZW-1:0] c_z     [0:N];
  logic signed [W-1:0]  c_ge    [0:N];
  logic signed [W-1:0]  c_gn    [0:N];
  logic signed [W-1:0]  c_d     [0:N];
  logic                 c_zero  [0:N];
  logic                 c_stop  [0:N];

  logic signed [XW-1:0] xi, yi;
  logic signed [UW-1:0] ui;
  logic                 neg, stop;
  always_comb begin
    neg  = d_de[W];
    stop = !d_d[W-1] && (d_d != '0);
    xi   = XW'(d_de) <<< VS;
    yi   = XW'(d_dn) <<< VS;
    ui   = stop ? (UW'(d_d) <<< SS) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (en) begin
      c_valid[0] <= d_valid;
    end
    if (en) begin
      c_x[0]    <= neg ? -xi : xi;
      c_y[0]    <= neg ? -yi : yi;
      c_u[0]    <= neg ? -ui : ui;
      c_v[0]    <= '0;
      c_z[0]    <= neg ? DEG180_Q16 : '0;
      c_ge[0]   <= d_ge;
      c_gn[0]   <= d_gn;
      c_d[0]    <= d_d;
      c_zero[0] <= (d_de == '0) && (d_dn == '0);
      c_stop[0] <= stop;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic up;
    assign up = !c_y[i][XW-1] && (c_y[i] != '0);
    always_ff @(posedge clk) begin
      if (rst) begin
        c_valid[i+1] <= 1'b0;
      end else if (en) begin
        c_valid[i+1] <= c_valid[i];
      end
      if (en) begin
        if (up) begin
          c_x[i+1] <= c_x[i] + (c_y[i] >>> i);
          c_y[i+1] <= c_y[i] - (c_x[i] >>> i);
          c_z[i+1] <= c_z[i] + atan_deg(i);
          c_u[i+1] <= c_u[i] - (c_v[i] >>> i);
          c_v[i+1] <= c_v[i] + (c_u[i] >>> i);
        end else begin
          c_x[i+1] <= c_x[i] - (c_y[i] >>> i);
          c_y[i+1] <= c_y[i] + (c_x[i] >>> i);
          c_z[i+1] <= c_z[i] - atan_deg(i);
          c_u[i+1] <= c_u[i] + (c_v[i] >>> i);
          c_v[i+1] <= c_v[i] - (c_u[i] >>> i);
        end
        c_ge[i+1]   <= c_ge[i];
        c_gn[i+1]   <= c_gn[i];
        c_d[i+1]    <= c_d[i];
        c_zero[i+1] <= c_zero[i];
        c_stop[i+1] <= c_stop[i];
      end
    end
  end

  // partial products and angle wrap
  logic                 p_valid, p_zero, p_stop;
  logic [47:0]          p_ulo, p_vlo;
  logic signed [40:0]   p_uhi, p_vhi;
  logic signed [ZW-1:0] p_z;
  logic signed [W-1:0]  p_ge, p_gn, p_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= c_valid[N];
    end
    if (en) begin
      p_ulo  <= {24'd0, c_u[N][23:0]} * {24'd0, INV_GAIN_Q24};
      p_vlo  <= {24'd0, c_v[N][23:0]} * {24'd0, INV_GAIN_Q24};
      p_uhi  <= 41'($signed(c_u[N][UW-1:24])) * $signed({17'd0, INV_GAIN_Q24});
      p_vhi  <= 41'($signed(c_v[N][UW-1:24])) * $signed({17'd0, INV_GAIN_Q24});
      p_z    <= c_z[N][ZW-1] ? c_z[N] + DEG360_Q16 : c_z[N];
      p_ge   <= c_ge[N];
      p_gn   <= c_gn[N];
      p_d    <= c_d[N];
      p_zero <= c_zero[N];
      p_stop <= c_stop[N];
    end
  end

  // sum, round, bearing
  logic signed [PW-1:0] half, su, sv;
  logic [ZW-1:0]        bsum;
  logic [18:0]          bq;
  always_comb begin
    half = PW'(1) <<< (23 + SS);
    su   = (PW'(p_uhi) <<< 24) + $signed(PW'(p_ulo)) + half;
    sv   = (PW'(p_vhi) <<< 24) + $signed(PW'(p_vlo)) + half;
    bsum = $unsigned(p_z) + ZW'(128);
    bq   = 19'(bsum >> 8);
  end

  logic                 r_valid;
  logic signed [W:0]    r_oe, r_on;
  logic [BW-1:0]        r_b;
  logic signed [W-1:0]  r_ge, r_gn;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (en) begin
      r_valid <= p_valid;
    end
    if (en) begin
      if (!p_stop) begin
        r_oe <= '0;
        r_on <= '0;
      end else if (p_zero) begin
        r_oe <= (W+1)'(p_d);
        r_on <= '0;
      end else begin
        r_oe <= (W+1)'(su >>> (24 + SS));
        r_on <= (W+1)'(sv >>> (24 + SS));
      end
      r_b  <= (p_zero || bq >= DEG360_Q8) ? '0 : BW'(bq);
      r_ge <= p_ge;
      r_gn <= p_gn;
    end
  end

  // saturate, output register
  localparam logic signed [W+1:0] HI = (W+2)'((64'sd1 <<< (W-1)) - 64'sd1);
  localparam logic signed [W+1:0] LO = -HI - (W+2)'(1);
  logic signed [W+1:0] te, tn;
  logic signed [W-1:0] se, sn;
  always_comb begin
    te = (W+2)'(r_ge) - (W+2)'(r_oe);
    tn = (W+2)'(r_gn) - (W+2)'(r_on);
    se = (te > HI) ? W'(HI) : (te < LO) ? W'(LO) : W'(te);
    sn = (tn > HI) ? W'(HI) : (tn < LO) ? W'(LO) : W'(tn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= r_valid;
    end
    if (en) begin
      m_tdata <= OBW'({r_b, sn, se});
    end
  end

endmodule

/* bench/wphs_checker.sv */
// ----------------------------------------------------------------------------
// wphs_checker
// Watches both stream channels of the waypoint bearing / standoff block,
// computes the expected target and bearing for every accepted input beat
// with a bit-exact CORDIC model, and compares each output beat in order.
// ----------------------------------------------------------------------------
module wphs_checker #(
  parameter int CW = 24,
  parameter int STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [((5*CW+7)/8)*8-1:0] s_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [((2*CW+wphs_pkg::BW+7)/8)*8-1:0] m_tdata,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic signed [CW-1:0] east;
    logic signed [CW-1:0] north;
    logic [wphs_pkg::BW-1:0] bearing;
  } target_t;

  target_t targets_due[$];

  function automatic longint asr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic logic signed [CW-1:0] clamp(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CW-1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  function automatic target_t solve_target(logic [5*CW-1:0] d);
    longint vn, ve, gn, ge, stop_d, de, dn, off_e, off_n, z;
    longint x, y, u, v, xs, ys, us, vs, half, b;
    longint ang [24];
    target_t r;
    ang = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1, 0};
    vn = longint'($signed(d[0*CW +: CW]));
    ve = longint'($signed(d[1*CW +: CW]));
    gn = longint'($signed(d[2*CW +: CW]));
    ge = longint'($signed(d[3*CW +: CW]));
    stop_d = longint'($signed(d[4*CW +: CW]));
    de = ge - ve;
    dn = gn - vn;
    off_e = 0;
    off_n = 0;
    z = 0;
    if (de == 0 && dn == 0) begin
      if (stop_d > 0) off_e = stop_d;
    end else begin
      x = de <<< (60 - CW);
      y = dn <<< (60 - CW);
      u = (stop_d > 0) ? (stop_d <<< (37 - CW)) : 0;
      v = 0;
      if (de < 0) begin
        x = -x; y = -y; u = -u; z = 180 * 65536;
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
        xs = asr(x, i); ys = asr(y, i); us = asr(u, i); vs = asr(v, i);
        if (y > 0) begin
          x = x + ys; y = y - xs; z += ang[i]; u = u - vs; v = v + us;
        end else begin
          x = x - ys; y = y + xs; z -= ang[i]; u = u + vs; v = v - us;
        end
      end
      if (stop_d > 0) begin
        half = longint'(1) <<< (23 + 37 - CW);
        off_e = asr(u * 10187995 + half, 24 + 37 - CW);
        off_n = asr(v * 10187995 + half, 24 + 37 - CW);
      end
    end
    while (z < 0) z += 360 * 65536;
    while (z >= 360 * 65536) z -= 360 * 65536;
    b = (z + 128) >>> 8;
    if (b >= 92160) b = 0;
    r.east = clamp(ge - off_e);
    r.north = clamp(gn - off_n);
    r.bearing = b[wphs_pkg::BW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  target_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      errors = 0;
      targets_due.delete();
    end else begin
      if (s_tvalid && s_tready) targets_due.push_back(solve_target(s_tdata[5*CW-1:0]));
      if (m_tvalid && m_tready) begin
        got.east = m_tdata[0 +: CW];
        got.north = m_tdata[CW +: CW];
        got.bearing = m_tdata[2*CW +: wphs_pkg::BW];
        if (targets_due.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          want = targets_due.pop_front();
          if (got.east != want.east) report_mismatch("target_east", got.east, want.east);
          if (got.north != want.north)
            report_mismatch("target_north", got.north, want.north);
          if (got.bearing != want.bearing)
            report_mismatch("bearing_deg", got.bearing, want.bearing);
        end
      end
    end
    pending <= targets_due.size();
  end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives directed and random waypoint beats into the bearing / standoff
// block with random idling and backpressure; the checker judges results.
// ----------------------------------------------------------------------------
module tb;

  localparam int CW = wphs_pkg::COORD_WIDTH_DEF;
  localparam int SW = ((5*CW+7)/8)*8;
  localparam int MW = ((2*CW+wphs_pkg::BW+7)/8)*8;
  localparam int WATCH_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MW-1:0] m_tdata;
  int errors, pending;
  int idle_pct = 17;
  bit hold_sink = 1'b0;
  int quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  waypoint_heading_standoff u_top (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  wphs_checker #(.CW(CW), .STAGES(wphs_pkg::CORDIC_STAGES_DEF)) u_check (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || hold_sink) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [CW-1:0] rnd_coord();
    case ($urandom_range(4))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(2000)) - 1000);
      2: return {1'b1, {(CW-1){1'b0}}};
      3: return {1'b0, {(CW-1){1'b1}}};
      default: return CW'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic send_waypoint(logic [CW-1:0] vn, ve, gn, ge, stop_d);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= SW'({stop_d, ge, gn, ve, vn});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || m_tvalid) @(posedge clk);
  endtask

  logic [CW-1:0] mx, mn, a, b;

  initial begin
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: quadrants, axes, zero vector, standoff signs, extremes
    send_waypoint(0, 0, 0, 0, 0);
    send_waypoint(0, 0, 0, 0, 256);
    send_waypoint(5, 7, 5, 7, mx);
    send_waypoint(0, 0, 0, 1000, 500);
    send_waypoint(0, 0, 1000, 0, 500);
    send_waypoint(0, 0, 0, -1000, 500);
    send_waypoint(0, 0, -1000, 0, 500);
    send_waypoint(0, 0, 1000, 1000, 300);
    send_waypoint(0, 0, 1000, -1000, 300);
    send_waypoint(0, 0, -1000, -1000, 300);
    send_waypoint(0, 0, -1000, 1000, 300);
    send_waypoint(0, 0, -1, 1000000, 0);
    send_waypoint(0, 0, -1, 1000000, -5);
    send_waypoint(0, 0, mn, mx, mn);
    send_waypoint(mx, mn, mn, mx, mx);
    send_waypoint(mn, mx, mx, mn, mx);
    send_waypoint(mx, mx, mn, mn, mx);
    send_waypoint(mn, mn, mx, mx, mx);
    send_waypoint(0, 0, mx, mx, mx);
    send_waypoint(0, 0, mn, mn, mx);
    send_waypoint(-1, -1, -1, -1, -1);
    send_waypoint(0, 0, 1, -1, 1);
    drain();
    // receiver holds off while the source keeps offering
    hold_sink = 1'b1;
    fork
      begin repeat (150) @(posedge clk); hold_sink = 1'b0; end
      for (int i = 0; i < 40; i++)
        send_waypoint(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    join
    drain();
    for (int i = 0; i < 500; i++) begin
      idle_pct = (i >= 200 && i < 300) ? 0 : 17;
      a = rnd_coord();
      b = rnd_coord();
      if ($urandom_range(9) == 0)
        send_waypoint(a, b, a, b, rnd_coord());
      else
        send_waypoint(a, b, rnd_coord(), rnd_coord(), rnd_coord());
    end
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
